// ===== src/khge_pkg.sv =====
`timescale 1ns / 1ps
package khge_pkg;

	typedef struct packed {
		logic signed [63:0] src_raw;
		logic signed [63:0] dst_raw;
		logic [31:0]        src_node;
		logic [31:0]        factor_base;
		logic [31:0]        in_degree;
	} in_word_t;

	typedef struct packed {
		logic [31:0] from_node;
		logic [31:0] to_node;
		logic [2:0]  factor_number;
		logic [31:0] probability;
		logic        last;
	} out_word_t;

	// classified edge, as queued between front and back
	typedef struct packed {
		logic [63:0] src_raw;
		logic [63:0] dst_raw;
		logic [31:0] src_node;
		logic [31:0] factor_base;
		logic [31:0] degree;
		logic [2:0]  count;
		logic [1:0]  fset;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_link_t;

	localparam logic [1:0] REG_SEED = 2'd0;
	localparam logic [1:0] REG_FSET = 2'd1;
	localparam logic [1:0] REG_GATE = 2'd2;

	localparam logic [1:0] FSET_TWO   = 2'd0;
	localparam logic [1:0] FSET_THREE = 2'd1;

	localparam logic [63:0] C_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] C_MIX1   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] C_MIX2   = 64'h94d049bb133111eb;
	localparam logic [63:0] C_KEY    = 64'h243f6a8885a308d3;

	// {lo, hi} in Q0.16 for factor fidx (zero-based)
	function automatic logic [31:0] range_bounds(input logic [1:0] fset,
			input logic [2:0] fidx);
		logic [15:0] lo;
		logic [15:0] hi;
		lo = 16'd0;
		hi = 16'd0;
		case (fset)
			FSET_TWO: begin
				if (fidx[0]) begin
					lo = 16'd36045; hi = 16'd62259;
				end else begin
					lo = 16'd6554;  hi = 16'd29491;
				end
			end
			FSET_THREE: begin
				case (fidx)
					3'd0: begin lo = 16'd3277;  hi = 16'd19661; end
					3'd1: begin lo = 16'd22938; hi = 16'd58982; end
					default: begin lo = 16'd9830; hi = 16'd36045; end
				endcase
			end
			default: begin
				case (fidx)
					3'd0: begin lo = 16'd1311;  hi = 16'd11796; end
					3'd1: begin lo = 16'd29491; hi = 16'd62259; end
					3'd2: begin lo = 16'd7864;  hi = 16'd29491; end
					3'd3: begin lo = 16'd3277;  hi = 16'd14418; end
					default: begin lo = 16'd1311; hi = 16'd11796; end
				endcase
			end
		endcase
		return {lo, hi};
	endfunction

endpackage

// ===== src/khge_front.sv =====
`timescale 1ns / 1ps
module khge_front #(
	parameter int MAX_FACTORS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  khge_pkg::in_word_t  in_word,
	input  logic [1:0]          fset,
	output khge_pkg::job_link_t link,
	input  logic                pop
);
	localparam logic [2:0] MAXF = 3'(MAX_FACTORS);

	khge_pkg::job_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic [2:0]     nf;
	khge_pkg::job_t job_in;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;

	always_comb begin
		case (fset)
			khge_pkg::FSET_TWO:   nf = 3'd2;
			khge_pkg::FSET_THREE: nf = 3'd3;
			default:              nf = 3'd5;
		endcase
		job_in.src_raw     = in_word.src_raw;
		job_in.dst_raw     = in_word.dst_raw;
		job_in.src_node    = in_word.src_node;
		job_in.factor_base = in_word.factor_base;
		job_in.degree      = (in_word.in_degree == 32'd0) ? 32'd1 : in_word.in_degree;
		job_in.count       = (nf < MAXF) ? nf : MAXF;
		job_in.fset        = fset;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign link.valid = (cnt_q != 2'd0);
	assign link.job   = mem_q[rd_ptr_q];

endmodule

// ===== src/khge_back.sv =====
`timescale 1ns / 1ps
module khge_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  khge_pkg::job_link_t  link,
	output logic                 pop,
	input  logic [63:0]          seed,
	input  logic                 gate_enable,
	output khge_pkg::out_word_t  out_word,
	output logic                 strobe
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_FAC  = 9'b000000010,
		S_PRE  = 9'b000000100,
		S_MUL  = 9'b000001000,
		S_MID  = 9'b000010000,
		S_POST = 9'b000100000,
		S_GH   = 9'b001000000,
		S_GL   = 9'b010000000,
		S_DIV  = 9'b100000000
	} state_t;

	state_t              state_q;
	logic                emit;
	khge_pkg::job_t      job_q;
	logic [2:0]          k_q;
	logic [1:0]          rnd_q;
	logic [1:0]          mph_q;
	logic                msel_q;
	logic [63:0]         a_q;
	logic [63:0]         acc_q;
	logic [63:0]         h_q;
	logic [47:0]         ph_q;
	logic [32:0]         dvd_q;
	logic [31:0]         rem_q;
	logic [31:0]         quo_q;
	logic [5:0]          dcnt_q;
	khge_pkg::out_word_t out_q;
	logic                strobe_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] mk;
	logic [63:0] key;
	logic [63:0] hin;
	logic [63:0] x1;
	logic [31:0] bounds;
	logic [15:0] dspan;
	logic [47:0] gsum;
	logic [31:0] g32;
	logic [32:0] trial;
	logic        qbit;
	logic        is_last;

	assign pop = (state_q == S_IDLE) && link.valid;

	always_comb begin
		mk     = msel_q ? khge_pkg::C_MIX2 : khge_pkg::C_MIX1;
		bounds = khge_pkg::range_bounds(job_q.fset, k_q);
		dspan  = bounds[15:0] - bounds[31:16];
		// one shared 32x32 multiplier for hash and gate
		mul_a = a_q[31:0];
		mul_b = mk[31:0];
		if (state_q == S_MUL) begin
			case (mph_q)
				2'd0:    begin mul_a = a_q[31:0];  mul_b = mk[31:0];  end
				2'd1:    begin mul_a = a_q[31:0];  mul_b = mk[63:32]; end
				default: begin mul_a = a_q[63:32]; mul_b = mk[31:0];  end
			endcase
		end else if (state_q == S_GH) begin
			mul_a = {16'd0, dspan};
			mul_b = h_q[63:32];
		end else if (state_q == S_GL) begin
			mul_a = {16'd0, dspan};
			mul_b = {11'd0, h_q[31:11]};
		end
		prod = {32'd0, mul_a} * {32'd0, mul_b};

		case (rnd_q)
			2'd1:    key = job_q.src_raw;
			2'd2:    key = job_q.dst_raw;
			default: key = {61'd0, k_q + 3'd1};
		endcase
		hin = (rnd_q == 2'd0) ? (seed ^ khge_pkg::C_KEY) : (h_q ^ key);
		x1  = hin + khge_pkg::C_GOLDEN;

		gsum = ph_q + {32'd0, prod[36:21]};
		g32  = {bounds[31:16], 16'd0} + gsum[47:16];

		trial = {rem_q, dvd_q[32]};
		qbit  = (trial >= {1'b0, job_q.degree});
		is_last = ((k_q + 3'd1) == job_q.count);
		emit = (state_q == S_DIV) && (dcnt_q == 6'd32);
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= link.job;
		case (state_q)
			S_FAC: begin
				rem_q  <= 32'd0;
				dcnt_q <= 6'd0;
				dvd_q  <= 33'h1_0000_0000;
			end
			S_PRE: begin
				a_q <= x1 ^ (x1 >> 30);
			end
			S_MUL: begin
				if (mph_q == 2'd0) acc_q <= prod;
				else acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
			S_MID: begin
				a_q <= acc_q ^ (acc_q >> 27);
			end
			S_POST: begin
				h_q <= acc_q ^ (acc_q >> 31);
			end
			S_GH: begin
				ph_q <= prod[47:0];
			end
			S_GL: begin
				dvd_q  <= {1'b0, g32};
				rem_q  <= 32'd0;
				dcnt_q <= 6'd0;
			end
			S_DIV: begin
				rem_q  <= qbit ? 32'(trial - {1'b0, job_q.degree}) : trial[31:0];
				quo_q  <= {quo_q[30:0], qbit};
				dvd_q  <= {dvd_q[31:0], 1'b0};
				dcnt_q <= dcnt_q + 6'd1;
			end
			default: ;
		endcase
		if (emit) begin
			out_q.from_node     <= job_q.src_node;
			out_q.to_node       <= job_q.factor_base + {29'd0, k_q};
			out_q.factor_number <= k_q + 3'd1;
			// last quotient bit arrives this cycle
			out_q.probability   <= quo_q[31] ? 32'hFFFF_FFFF : {quo_q[30:0], qbit};
			out_q.last          <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= 3'd0;
			rnd_q    <= 2'd0;
			mph_q    <= 2'd0;
			msel_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			case (state_q)
				S_IDLE: begin
					if (link.valid) begin
						k_q     <= 3'd0;
						state_q <= S_FAC;
					end
				end
				S_FAC: begin
					rnd_q   <= 2'd0;
					state_q <= gate_enable ? S_PRE : S_DIV;
				end
				S_PRE: begin
					mph_q   <= 2'd0;
					msel_q  <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mph_q == 2'd2) begin
						mph_q   <= 2'd0;
						state_q <= msel_q ? S_POST : S_MID;
					end else begin
						mph_q <= mph_q + 2'd1;
					end
				end
				S_MID: begin
					msel_q  <= 1'b1;
					state_q <= S_MUL;
				end
				S_POST: begin
					rnd_q   <= rnd_q + 2'd1;
					state_q <= (rnd_q == 2'd3) ? S_GH : S_PRE;
				end
				S_GH: state_q <= S_GL;
				S_GL: state_q <= S_DIV;
				S_DIV: begin
					if (emit) begin
						k_q     <= k_q + 3'd1;
						state_q <= is_last ? S_IDLE : S_FAC;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_word = out_q;
	assign strobe   = strobe_q;

endmodule

// ===== src/keyed_hash_gated_edge_expander_core.sv =====
`timescale 1ns / 1ps
// Each result word runs through the shared 32x32 multiplier (hash chain and gate, gating on only)
//   and the 1-bit-per-cycle divider; the back end takes the next edge only after its last word.
// A two-deep edge queue keeps accepting while the back end works; busy when it is full.
// Reset (arst_n low, async): config registers cleared to zero, queue empty, back end idle, no strobe.
// Result words cannot be stalled: strobe is high for exactly one cycle per word.
module keyed_hash_gated_edge_expander_core #(
	parameter int MAX_FACTORS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	// edge input
	input  logic                start,
	output logic                busy,
	input  khge_pkg::in_word_t  in_word,
	// result output
	output khge_pkg::out_word_t out_word,
	output logic                strobe,
	// config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);
	logic [63:0]         seed_q;
	logic [1:0]          fset_q;
	logic                gate_q;
	logic                cfg_wr;
	logic                pop;
	khge_pkg::job_link_t link;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// registers sit on 8-byte strides: seed, factor_set, gate_enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
			fset_q <= 2'd0;
			gate_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				khge_pkg::REG_SEED: seed_q <= pwdata;
				khge_pkg::REG_FSET: fset_q <= pwdata[1:0];
				khge_pkg::REG_GATE: gate_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			khge_pkg::REG_SEED: prdata = seed_q;
			khge_pkg::REG_FSET: prdata = {62'd0, fset_q};
			khge_pkg::REG_GATE: prdata = {63'd0, gate_q};
			default:            prdata = 64'd0;
		endcase
	end

	// front: accept, fix zero degree, resolve factor count, queue
	khge_front #(
		.MAX_FACTORS(MAX_FACTORS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_word (in_word),
		.fset    (fset_q),
		.link    (link),
		.pop     (pop)
	);

	// back: per factor, 4-round hash chain and gate (gating on only), divide, emit
	khge_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.link        (link),
		.pop         (pop),
		.seed        (seed_q),
		.gate_enable (gate_q),
		.out_word    (out_word),
		.strobe      (strobe)
	);

endmodule
